// ----- hdl/omga_pkg.sv -----
// shared constants, types and helpers for the onemax generation step block
// no dependencies

package omga_pkg;

   // defaults for the top level parameters
   localparam int GENE_COUNT_DEF = 10;
   localparam int POP_SIZE_DEF   = 1024;

   // widest genome supported and the width of its ones count
   localparam int MAX_GENES = 64;
   localparam int CNT_W     = 7;

   // fixed widths of the request and response fields
   localparam int INDEX_W = 10;
   localparam int FIT_OUT_W = 4;
   localparam int POINT_W = 4;
   localparam int GEN_W   = 16;

   // request command codes
   localparam logic CMD_LOAD       = 1'b0;
   localparam logic CMD_GENERATION = 1'b1;

   // read address select codes
   localparam logic [1:0] RD_SCAN   = 2'd0;
   localparam logic [1:0] RD_BEST   = 2'd1;
   localparam logic [1:0] RD_SECOND = 2'd2;

   typedef struct packed {
      logic       capture;      // latch request fields, restart scan
      logic       scan_issue;   // read next member of the scan
      logic [1:0] rd_sel;       // memory read address select
      logic       grab_a;       // latch the fittest parent
      logic       grab_b;       // latch the second parent
      logic       mix;          // crossover and mutation into child registers
      logic       load_we;      // write the loaded genome
      logic       insert_we;    // write the chosen child, send result
      logic       respond_load; // send result of a load beat
   } dp_cmd_type;

   typedef struct packed {
      logic scan_last;          // scan address is the last member
   } dp_status_type;

   function automatic logic [CNT_W-1:0] ones_count(input logic [MAX_GENES-1:0] g);
      logic [CNT_W-1:0] c;
      c = '0;
      for (int i = 0; i < MAX_GENES; i++) begin
         c = c + CNT_W'(g[i]);
      end
      return c;
   endfunction

endpackage

// ----- hdl/omga_ctrl.sv -----
// sequencer for the onemax generation step: load write, population scan,
// parent fetch, mixing and insert; depends on omga_pkg

module omga_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   req_command,
   input  omga_pkg::dp_status_type status,
   output omga_pkg::dp_cmd_type    cmd,
   output logic                   busy
);
   import omga_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_LOAD  = 4'd1;
   localparam logic [3:0] S_SCAN  = 4'd2;
   localparam logic [3:0] S_DRAIN = 4'd3;
   localparam logic [3:0] S_RDA   = 4'd4;
   localparam logic [3:0] S_RDB   = 4'd5;
   localparam logic [3:0] S_GRB   = 4'd6;
   localparam logic [3:0] S_MIX   = 4'd7;
   localparam logic [3:0] S_INS   = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_sel = RD_SCAN;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in = (req_command == CMD_GENERATION) ? S_SCAN : S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.load_we      = 1'b1;
            cmd.respond_load = 1'b1;
            state_in         = S_IDLE;
         end
         S_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (status.scan_last) state_in = S_DRAIN;
         end
         // last read member updates the trackers here
         S_DRAIN: state_in = S_RDA;
         S_RDA: begin
            cmd.rd_sel = RD_BEST;
            state_in   = S_RDB;
         end
         S_RDB: begin
            cmd.rd_sel = RD_SECOND;
            cmd.grab_a = 1'b1;
            state_in   = S_GRB;
         end
         S_GRB: begin
            cmd.grab_b = 1'b1;
            state_in   = S_MIX;
         end
         S_MIX: begin
            cmd.mix  = 1'b1;
            state_in = S_INS;
         end
         S_INS: begin
            cmd.insert_we = 1'b1;
            state_in      = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ----- hdl/omga_datapath.sv -----
// population memory, fitness trackers, crossover and mutation, result registers
// depends on omga_pkg

module omga_datapath #(
   parameter int GENE_COUNT = omga_pkg::GENE_COUNT_DEF,
   parameter int POP_SIZE   = omga_pkg::POP_SIZE_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  omga_pkg::dp_cmd_type                 cmd,
   output omga_pkg::dp_status_type              status,
   input  logic [omga_pkg::INDEX_W-1:0]         req_load_index,
   input  logic [omga_pkg::INDEX_W-1:0]         req_load_genome,
   input  logic [omga_pkg::POINT_W-1:0]         req_crossover_point,
   input  logic                                 req_mutate,
   input  logic [omga_pkg::POINT_W-1:0]         req_mutation_point_first,
   input  logic [omga_pkg::POINT_W-1:0]         req_mutation_point_second,
   output logic                                 rsp_valid,
   output logic [omga_pkg::FIT_OUT_W-1:0]       rsp_fittest_child_fitness,
   output logic [omga_pkg::FIT_OUT_W-1:0]       rsp_inserted_fitness,
   output logic [omga_pkg::INDEX_W-1:0]         rsp_replaced_index,
   output logic                                 rsp_target_reached,
   output logic [omga_pkg::GEN_W-1:0]           rsp_generation_number
);
   import omga_pkg::*;

   localparam int IDX_W = $clog2(POP_SIZE);
   localparam int FIT_W = $clog2(GENE_COUNT + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POP_SIZE - 1);

   // request fields held for the whole item
   logic [INDEX_W-1:0] load_index_ff;
   logic [INDEX_W-1:0] load_genome_ff;
   logic [POINT_W-1:0] xover_ff;
   logic               mutate_ff;
   logic [POINT_W-1:0] mpoint_a_ff;
   logic [POINT_W-1:0] mpoint_b_ff;

   logic [GENE_COUNT-1:0] pop_mem_ff [POP_SIZE];
   logic [GENE_COUNT-1:0] rd_data_ff;
   logic [IDX_W-1:0]      rd_addr;
   logic                  mem_we;
   logic [IDX_W-1:0]      wr_addr;
   logic [GENE_COUNT-1:0] wr_data;

   logic [IDX_W-1:0] scan_addr_ff;
   logic             s1_valid_ff;
   logic [IDX_W-1:0] s1_idx_ff;

   logic [IDX_W-1:0] best_ff, second_ff, least_ff;
   logic [FIT_W-1:0] best_fit_ff, second_fit_ff, least_fit_ff;
   logic [FIT_W-1:0] scan_fit;

   logic [GENE_COUNT-1:0] parent_a_ff, parent_b_ff;
   logic [GENE_COUNT-1:0] child_a_ff, child_b_ff;
   logic [GENE_COUNT-1:0] child_a_in, child_b_in;
   logic [GENE_COUNT-1:0] xmask, fmask_a, fmask_b;
   logic [FIT_W-1:0]      fit_a, fit_b, fit_ins;
   logic [GENE_COUNT-1:0] inserted;
   logic                  load_in_range;
   logic [GEN_W-1:0]      gen_ff;
   logic [GEN_W-1:0]      gen_next;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         load_index_ff  <= req_load_index;
         load_genome_ff <= req_load_genome;
         xover_ff       <= req_crossover_point;
         mutate_ff      <= req_mutate;
         mpoint_a_ff    <= req_mutation_point_first;
         mpoint_b_ff    <= req_mutation_point_second;
      end
   end

   // read address and write port selection
   always_comb begin
      case (cmd.rd_sel)
         RD_BEST:   rd_addr = best_ff;
         RD_SECOND: rd_addr = second_ff;
         default:   rd_addr = scan_addr_ff;
      endcase
   end

   assign load_in_range = (32'(load_index_ff) < 32'(POP_SIZE));
   assign mem_we  = (cmd.load_we && load_in_range) || cmd.insert_we;
   assign wr_addr = cmd.insert_we ? least_ff : IDX_W'(load_index_ff);
   assign wr_data = cmd.insert_we ? inserted : GENE_COUNT'(load_genome_ff);

   always_ff @(posedge clock) begin
      rd_data_ff <= pop_mem_ff[rd_addr];
      if (mem_we) pop_mem_ff[wr_addr] <= wr_data;
   end

   // scan address and one-stage read pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_addr_ff <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         if (cmd.capture) begin
            scan_addr_ff <= '0;
         end else if (cmd.scan_issue) begin
            scan_addr_ff <= scan_addr_ff + IDX_W'(1);
         end
         s1_valid_ff <= cmd.scan_issue;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff <= scan_addr_ff;
   end

   assign status.scan_last = (scan_addr_ff == LAST_IDX);
   assign scan_fit = FIT_W'(ones_count(MAX_GENES'(rd_data_ff)));

   // top two and least fit trackers
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         if (s1_idx_ff == '0) begin
            best_ff      <= '0;
            best_fit_ff  <= scan_fit;
            least_ff     <= '0;
            least_fit_ff <= scan_fit;
         end else begin
            if (scan_fit > best_fit_ff) begin
               second_ff     <= best_ff;
               second_fit_ff <= best_fit_ff;
               best_ff       <= s1_idx_ff;
               best_fit_ff   <= scan_fit;
            end else if ((s1_idx_ff == IDX_W'(1)) || (scan_fit > second_fit_ff)) begin
               // member one always seeds the second slot when it does not lead
               second_ff     <= s1_idx_ff;
               second_fit_ff <= scan_fit;
            end
            if (scan_fit < least_fit_ff) begin
               least_ff     <= s1_idx_ff;
               least_fit_ff <= scan_fit;
            end
         end
      end
   end

   // crossover and mutation masks
   always_comb begin
      for (int i = 0; i < GENE_COUNT; i++) begin
         xmask[i]   = (32'(xover_ff) > 32'(i));
         fmask_a[i] = mutate_ff && (32'(mpoint_a_ff) == 32'(i));
         fmask_b[i] = mutate_ff && (32'(mpoint_b_ff) == 32'(i));
      end
      child_a_in = (parent_a_ff ^ ((parent_a_ff ^ parent_b_ff) & xmask)) ^ fmask_a;
      child_b_in = (parent_b_ff ^ ((parent_a_ff ^ parent_b_ff) & xmask)) ^ fmask_b;
   end

   always_ff @(posedge clock) begin
      if (cmd.grab_a) parent_a_ff <= rd_data_ff;
      if (cmd.grab_b) parent_b_ff <= rd_data_ff;
      if (cmd.mix) begin
         child_a_ff <= child_a_in;
         child_b_ff <= child_b_in;
      end
   end

   assign fit_a    = FIT_W'(ones_count(MAX_GENES'(child_a_ff)));
   assign fit_b    = FIT_W'(ones_count(MAX_GENES'(child_b_ff)));
   assign inserted = (fit_a > fit_b) ? child_a_ff : child_b_ff;
   assign fit_ins  = (fit_a > fit_b) ? fit_a : fit_b;
   assign gen_next = gen_ff + GEN_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff    <= '0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cmd.insert_we || cmd.respond_load;
         if (cmd.insert_we) gen_ff <= gen_next;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.insert_we) begin
         rsp_fittest_child_fitness <= FIT_OUT_W'(fit_a);
         rsp_inserted_fitness      <= FIT_OUT_W'(fit_ins);
         rsp_replaced_index        <= INDEX_W'(least_ff);
         rsp_target_reached        <= (child_a_ff == '1);
         rsp_generation_number     <= gen_next;
      end else if (cmd.respond_load) begin
         rsp_fittest_child_fitness <= '0;
         rsp_inserted_fitness      <= '0;
         rsp_replaced_index        <= load_index_ff;
         rsp_target_reached        <= 1'b0;
         rsp_generation_number     <= gen_ff;
      end
   end

endmodule

// ----- hdl/onemax_genetic_generation_step.sv -----
// OneMax generation step: a population of bit-string genomes with load and
// generation commands. A load beat is busy for one cycle and its result strobes
// on rsp_valid in the cycle after. A generation beat makes one pass over the
// population memory, one member per cycle on its single read port, and
// finds the two fittest and the least fit at once, then the two parents
// are read back, mixed and the chosen child is written. The result strobes
// for one cycle right after busy falls, and the receiver must take it then
// since there is no backpressure. Population slots hold garbage until loaded;
// load every slot before running a generation.
// depends on omga_pkg, omga_ctrl, omga_datapath

module onemax_genetic_generation_step #(
   parameter int GENE_COUNT = omga_pkg::GENE_COUNT_DEF,
   parameter int POP_SIZE   = omga_pkg::POP_SIZE_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_command,
   input  logic [omga_pkg::INDEX_W-1:0]   req_load_index,
   input  logic [omga_pkg::INDEX_W-1:0]   req_load_genome,
   input  logic [omga_pkg::POINT_W-1:0]   req_crossover_point,
   input  logic                           req_mutate,
   input  logic [omga_pkg::POINT_W-1:0]   req_mutation_point_first,
   input  logic [omga_pkg::POINT_W-1:0]   req_mutation_point_second,
   output logic                           rsp_valid,
   output logic [omga_pkg::FIT_OUT_W-1:0] rsp_fittest_child_fitness,
   output logic [omga_pkg::FIT_OUT_W-1:0] rsp_inserted_fitness,
   output logic [omga_pkg::INDEX_W-1:0]   rsp_replaced_index,
   output logic                           rsp_target_reached,
   output logic [omga_pkg::GEN_W-1:0]     rsp_generation_number
);
   import omga_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   omga_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .status      (status),
      .cmd         (cmd),
      .busy        (busy)
   );

   omga_datapath #(
      .GENE_COUNT (GENE_COUNT),
      .POP_SIZE   (POP_SIZE)
   ) u_datapath (
      .clock                     (clock),
      .reset                     (reset),
      .cmd                       (cmd),
      .status                    (status),
      .req_load_index            (req_load_index),
      .req_load_genome           (req_load_genome),
      .req_crossover_point       (req_crossover_point),
      .req_mutate                (req_mutate),
      .req_mutation_point_first  (req_mutation_point_first),
      .req_mutation_point_second (req_mutation_point_second),
      .rsp_valid                 (rsp_valid),
      .rsp_fittest_child_fitness (rsp_fittest_child_fitness),
      .rsp_inserted_fitness      (rsp_inserted_fitness),
      .rsp_replaced_index        (rsp_replaced_index),
      .rsp_target_reached        (rsp_target_reached),
      .rsp_generation_number     (rsp_generation_number)
   );

endmodule

// ----- bench/onemax_genetic_generation_step_tb.sv -----
// testbench for onemax_genetic_generation_step: fills every population slot, then runs
// directed and random load/generation beats against a scoreboard that mirrors the population
// depends on omga_pkg and onemax_genetic_generation_step
`timescale 1ns / 1ps

module onemax_genetic_generation_step_tb;
   import omga_pkg::*;

   localparam int GENES       = GENE_COUNT_DEF;
   localparam int POP         = POP_SIZE_DEF;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int RANDOM_BEATS = 290;

   typedef struct {
      logic               command;
      logic [INDEX_W-1:0] load_index;
      logic [INDEX_W-1:0] load_genome;
      logic [POINT_W-1:0] xover_point;
      logic               mutate;
      logic [POINT_W-1:0] point_first;
      logic [POINT_W-1:0] point_second;
   } gen_request_type;

   typedef struct {
      logic [FIT_OUT_W-1:0] fittest_fit;
      logic [FIT_OUT_W-1:0] inserted_fit;
      logic [INDEX_W-1:0]   replaced_index;
      logic                 target;
      logic [GEN_W-1:0]     generation;
   } gen_result_type;

   class onemax_scoreboard_type;
      bit [GENES-1:0] genomes[POP];
      bit [GEN_W-1:0] gen_count;
      gen_result_type result_q[$];
      int             mismatch_count;

      // mirror one accepted beat and queue the result it must produce
      function void note_request(gen_request_type r);
         gen_result_type res;
         int             best, second, least, f, best_fit, second_fit, least_fit;
         int             fit_a, fit_b;
         bit [GENES-1:0] child_a, child_b, swap_mask, diff, inserted;
         res = '{default: '0};
         if (r.command == CMD_LOAD) begin
            if (r.load_index < POP) genomes[r.load_index] = r.load_genome[GENES-1:0];
            res.replaced_index = r.load_index;
            res.generation     = gen_count;
            result_q = {result_q, res};
            return;
         end
         gen_count = gen_count + 1'b1;
         if ($countones(genomes[0]) >= $countones(genomes[1])) begin
            best = 0;
            second = 1;
         end else begin
            best = 1;
            second = 0;
         end
         best_fit   = $countones(genomes[best]);
         second_fit = $countones(genomes[second]);
         for (int i = 2; i < POP; i++) begin
            f = $countones(genomes[i]);
            if (f > best_fit) begin
               second = best;
               second_fit = best_fit;
               best = i;
               best_fit = f;
            end else if (f > second_fit) begin
               second = i;
               second_fit = f;
            end
         end
         child_a = genomes[best];
         child_b = genomes[second];
         swap_mask = (r.xover_point >= GENES) ? '1 : GENES'((1 << r.xover_point) - 1);
         diff = (child_a ^ child_b) & swap_mask;
         child_a ^= diff;
         child_b ^= diff;
         if (r.mutate) begin
            if (r.point_first < GENES) child_a[r.point_first] = ~child_a[r.point_first];
            if (r.point_second < GENES) child_b[r.point_second] = ~child_b[r.point_second];
         end
         fit_a = $countones(child_a);
         fit_b = $countones(child_b);
         inserted = (fit_a > fit_b) ? child_a : child_b;
         // least fit is taken before the insert, lowest index wins a tie
         least = 0;
         least_fit = $countones(genomes[0]);
         for (int i = 1; i < POP; i++) begin
            f = $countones(genomes[i]);
            if (f < least_fit) begin
               least_fit = f;
               least = i;
            end
         end
         genomes[least] = inserted;
         res.fittest_fit    = fit_a[FIT_OUT_W-1:0];
         res.inserted_fit   = (fit_a > fit_b) ? fit_a[FIT_OUT_W-1:0] : fit_b[FIT_OUT_W-1:0];
         res.replaced_index = least[INDEX_W-1:0];
         res.target         = (child_a == '1);
         res.generation     = gen_count;
         result_q = {result_q, res};
      endfunction

      function void check_result(gen_result_type got);
         gen_result_type want;
         if (result_q.size() == 0) begin
            if (mismatch_count < 10)
               $display("[%0t] unexpected result beat: fit=%0d ins=%0d idx=%0d tgt=%0d gen=%0d",
                        $realtime, got.fittest_fit, got.inserted_fit, got.replaced_index,
                        got.target, got.generation);
            mismatch_count++;
            return;
         end
         want = result_q.pop_front();
         if (got.fittest_fit !== want.fittest_fit || got.inserted_fit !== want.inserted_fit ||
             got.replaced_index !== want.replaced_index || got.target !== want.target ||
             got.generation !== want.generation) begin
            if (mismatch_count < 10)
               $display("[%0t] result mismatch: exp fit=%0d ins=%0d idx=%0d tgt=%0d gen=%0d, %s",
                        $realtime, want.fittest_fit, want.inserted_fit, want.replaced_index,
                        want.target, want.generation,
                        $sformatf("got fit=%0d ins=%0d idx=%0d tgt=%0d gen=%0d",
                                  got.fittest_fit, got.inserted_fit, got.replaced_index,
                                  got.target, got.generation));
            mismatch_count++;
         end
      endfunction

      function int pending();
         return result_q.size();
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_command;
   logic [INDEX_W-1:0] req_load_index;
   logic [INDEX_W-1:0] req_load_genome;
   logic [POINT_W-1:0] req_crossover_point;
   logic               req_mutate;
   logic [POINT_W-1:0] req_mutation_point_first;
   logic [POINT_W-1:0] req_mutation_point_second;
   logic               rsp_valid;
   logic [FIT_OUT_W-1:0] rsp_fittest_child_fitness;
   logic [FIT_OUT_W-1:0] rsp_inserted_fitness;
   logic [INDEX_W-1:0]   rsp_replaced_index;
   logic                 rsp_target_reached;
   logic [GEN_W-1:0]     rsp_generation_number;

   onemax_scoreboard_type board = new;

   onemax_genetic_generation_step u_top (
      .clock                     (clock),
      .reset                     (reset),
      .start                     (start),
      .busy                      (busy),
      .req_command               (req_command),
      .req_load_index            (req_load_index),
      .req_load_genome           (req_load_genome),
      .req_crossover_point       (req_crossover_point),
      .req_mutate                (req_mutate),
      .req_mutation_point_first  (req_mutation_point_first),
      .req_mutation_point_second (req_mutation_point_second),
      .rsp_valid                 (rsp_valid),
      .rsp_fittest_child_fitness (rsp_fittest_child_fitness),
      .rsp_inserted_fitness      (rsp_inserted_fitness),
      .rsp_replaced_index        (rsp_replaced_index),
      .rsp_target_reached        (rsp_target_reached),
      .rsp_generation_number     (rsp_generation_number)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         board.check_result('{rsp_fittest_child_fitness, rsp_inserted_fitness,
                              rsp_replaced_index, rsp_target_reached, rsp_generation_number});
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic gen_request_type load_beat(int idx, int genome);
      gen_request_type r;
      r.command         = CMD_LOAD;
      r.load_index      = idx[INDEX_W-1:0];
      r.load_genome     = genome[INDEX_W-1:0];
      r.xover_point     = 4'($urandom_range(0, 15));
      r.mutate          = 1'($urandom_range(0, 1));
      r.point_first     = 4'($urandom_range(0, 15));
      r.point_second    = 4'($urandom_range(0, 15));
      return r;
   endfunction

   function automatic gen_request_type generation_beat(int cp, bit mut, int pa, int pb);
      gen_request_type r;
      r.command         = CMD_GENERATION;
      r.load_index      = INDEX_W'($urandom_range(0, 1023));
      r.load_genome     = INDEX_W'($urandom_range(0, 1023));
      r.xover_point     = cp[POINT_W-1:0];
      r.mutate          = mut;
      r.point_first     = pa[POINT_W-1:0];
      r.point_second    = pb[POINT_W-1:0];
      return r;
   endfunction

   // genomes spread over the whole fitness range, the extremes favored
   function automatic int random_genome();
      case ($urandom_range(0, 3))
         0: return 1023;
         1: return 1023 ^ (1 << $urandom_range(0, 9));
         2: return ($urandom_range(0, 1) != 0) ? 0 : (1 << $urandom_range(0, 9));
         default: return $urandom_range(0, 1023);
      endcase
   endfunction

   // called at a falling edge; returns at a falling edge after the beat
   task automatic send(gen_request_type r);
      int gap;
      req_command               = r.command;
      req_load_index            = r.load_index;
      req_load_genome           = r.load_genome;
      req_crossover_point       = r.xover_point;
      req_mutate                = r.mutate;
      req_mutation_point_first  = r.point_first;
      req_mutation_point_second = r.point_second;
      start                     = 1'b1;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      board.note_request(r);
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_drain();
      while (board.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      reset                     = 1'b1;
      start                     = 1'b0;
      req_command               = CMD_LOAD;
      req_load_index            = '0;
      req_load_genome           = '0;
      req_crossover_point       = '0;
      req_mutate                = 1'b0;
      req_mutation_point_first  = '0;
      req_mutation_point_second = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // every slot must hold a genome before the first generation
      for (int i = 0; i < POP; i++) send(load_beat(i, $urandom_range(0, 1023)));
      start = 1'b0;
      wait_drain();

      send(generation_beat(0, 1'b0, 0, 0));
      send(generation_beat(15, 1'b0, 0, 0));
      send(generation_beat(10, 1'b1, 10, 15));
      send(generation_beat(9, 1'b1, 0, 9));
      send(load_beat(0, 0));
      send(load_beat(1, 0));
      send(load_beat(1023, 1023));
      send(load_beat(512, 1023));
      send(generation_beat(5, 1'b1, 9, 0));
      send(load_beat(0, 1023));
      send(load_beat(1, 1023));
      send(generation_beat(0, 1'b1, 3, 3));
      send(generation_beat(15, 1'b0, 0, 0));
      send(load_beat(0, 1022));
      send(load_beat(1, 1023));
      send(generation_beat(1, 1'b1, 15, 1));
      send(load_beat(700, 0));
      send(load_beat(300, 0));
      send(generation_beat(4, 1'b0, 0, 0));
      start = 1'b0;
      wait_drain();

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if ($urandom_range(0, 99) < 55) begin
            if ($urandom_range(0, 9) == 0)
               send(load_beat($urandom_range(0, 1), random_genome()));
            else
               send(load_beat($urandom_range(0, 1023), random_genome()));
         end else begin
            send(generation_beat(($urandom_range(0, 3) == 0) ? $urandom_range(10, 15)
                                                            : $urandom_range(0, 9),
                                 1'($urandom_range(0, 1)),
                                 $urandom_range(0, 15), $urandom_range(0, 15)));
         end
         if (n == RANDOM_BEATS / 2) begin
            start = 1'b0;
            wait_drain();
         end
      end
      start = 1'b0;

      wait_drain();
      repeat (20) @(posedge clock);
      if (board.mismatch_count == 0 && board.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
